/* sv/assert_macros.svh */
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sip_pkg.sv */
// Shared constant for the segment intersection point block
package sip_pkg;
    localparam int COORD_BITS = 20;
endpackage

/* sv/segment_intersection_point.sv */
// Throughput: one word per cycle; a stall at the output holds every stage in place.
// Six arithmetic stages, then one restoring divider stage per quotient bit, then the
// saturating output register.
// Reset clears all valid bits; data registers are not reset.
// Segment crossing test and crossing point, fully pipelined
`include "assert_macros.svh"
module segment_intersection_point #(
    parameter int COORD_BITS = sip_pkg::COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] a_start_x,
    input  logic signed [COORD_BITS-1:0] a_start_z,
    input  logic signed [COORD_BITS-1:0] a_end_x,
    input  logic signed [COORD_BITS-1:0] a_end_z,
    input  logic signed [COORD_BITS-1:0] b_start_x,
    input  logic signed [COORD_BITS-1:0] b_start_z,
    input  logic signed [COORD_BITS-1:0] b_end_x,
    input  logic signed [COORD_BITS-1:0] b_end_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic                         parallel,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_z
);
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int OW = PW + 1;
    localparam int XW = 2 * CB;
    localparam int CW = XW + 1;
    localparam int MW = CW + DW;
    localparam int NW = MW + 1;
    localparam int QB = CB + 1;
    localparam int RW = OW + QB;
    localparam int NS = 6 + QB + 1;
    localparam logic [QB-1:0] LIM = QB'(1) << (CB - 1);

    logic [NS-1:0] vld_reg;
    logic          en;

    assign en       = !vld_reg[NS-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // stage 1: differences and on-segment checks
    logic signed [DW-1:0] ex_reg, ez_reg, fx_reg, fz_reg;
    logic signed [DW-1:0] g1x_reg, g1z_reg, g2x_reg, g2z_reg;
    logic signed [DW-1:0] h1x_reg, h1z_reg, h2x_reg, h2z_reg;
    logic signed [CB-1:0] a1x_reg, a1z_reg, a2x_reg, a2z_reg;
    logic signed [CB-1:0] b1x_reg, b1z_reg, b2x_reg, b2z_reg;
    logic [3:0]           win1_reg;
    logic [3:0]           win_next;

    function automatic logic between(logic signed [CB-1:0] p, logic signed [CB-1:0] q,
                                     logic signed [CB-1:0] r);
        return ((q <= p) || (q <= r)) && ((q >= p) || (q >= r));
    endfunction

    always_comb
    begin
        win_next[0] = between(a_start_x, b_start_x, a_end_x)
                   && between(a_start_z, b_start_z, a_end_z);
        win_next[1] = between(a_start_x, b_end_x, a_end_x)
                   && between(a_start_z, b_end_z, a_end_z);
        win_next[2] = between(b_start_x, a_start_x, b_end_x)
                   && between(b_start_z, a_start_z, b_end_z);
        win_next[3] = between(b_start_x, a_end_x, b_end_x)
                   && between(b_start_z, a_end_z, b_end_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg   <= DW'(a_end_x) - DW'(a_start_x);
            ez_reg   <= DW'(a_end_z) - DW'(a_start_z);
            fx_reg   <= DW'(b_end_x) - DW'(b_start_x);
            fz_reg   <= DW'(b_end_z) - DW'(b_start_z);
            g1x_reg  <= DW'(b_start_x) - DW'(a_end_x);
            g1z_reg  <= DW'(b_start_z) - DW'(a_end_z);
            g2x_reg  <= DW'(b_end_x) - DW'(a_end_x);
            g2z_reg  <= DW'(b_end_z) - DW'(a_end_z);
            h1x_reg  <= DW'(a_start_x) - DW'(b_end_x);
            h1z_reg  <= DW'(a_start_z) - DW'(b_end_z);
            h2x_reg  <= DW'(a_end_x) - DW'(b_end_x);
            h2z_reg  <= DW'(a_end_z) - DW'(b_end_z);
            a1x_reg  <= a_start_x;
            a1z_reg  <= a_start_z;
            a2x_reg  <= a_end_x;
            a2z_reg  <= a_end_z;
            b1x_reg  <= b_start_x;
            b1z_reg  <= b_start_z;
            b2x_reg  <= b_end_x;
            b2z_reg  <= b_end_z;
            win1_reg <= win_next;
        end
    end

    // stage 2: products
    logic signed [PW-1:0] op_reg [0:7];
    logic signed [XW-1:0] cp_reg [0:3];
    logic signed [PW-1:0] dp0_reg, dp1_reg;
    logic signed [DW-1:0] ex2_reg, ez2_reg, fx2_reg, fz2_reg;
    logic [3:0]           win2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0] <= ez_reg * g1x_reg;
            op_reg[1] <= ex_reg * g1z_reg;
            op_reg[2] <= ez_reg * g2x_reg;
            op_reg[3] <= ex_reg * g2z_reg;
            op_reg[4] <= fz_reg * h1x_reg;
            op_reg[5] <= fx_reg * h1z_reg;
            op_reg[6] <= fz_reg * h2x_reg;
            op_reg[7] <= fx_reg * h2z_reg;
            cp_reg[0] <= a1x_reg * a2z_reg;
            cp_reg[1] <= a1z_reg * a2x_reg;
            cp_reg[2] <= b1x_reg * b2z_reg;
            cp_reg[3] <= b1z_reg * b2x_reg;
            dp0_reg   <= ex_reg * fz_reg;
            dp1_reg   <= ez_reg * fx_reg;
            ex2_reg   <= ex_reg;
            ez2_reg   <= ez_reg;
            fx2_reg   <= fx_reg;
            fz2_reg   <= fz_reg;
            win2_reg  <= win1_reg;
        end
    end

    // stage 3: orientations, hit decision, determinant terms
    logic [1:0]           oc [0:3];
    logic signed [OW-1:0] ov [0:3];
    logic                 hit_next;
    logic                 hit3_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    logic signed [OW-1:0] den3_reg;
    logic signed [DW-1:0] ex3_reg, ez3_reg, fx3_reg, fz3_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ov[k] = OW'(op_reg[2*k]) - OW'(op_reg[2*k+1]);
            oc[k] = {ov[k][OW-1], (ov[k] != '0) && !ov[k][OW-1]};
        end
        hit_next = ((oc[0] != oc[1]) && (oc[2] != oc[3]))
                || ((oc[0] == 2'b00) && win2_reg[0])
                || ((oc[1] == 2'b00) && win2_reg[1])
                || ((oc[2] == 2'b00) && win2_reg[2])
                || ((oc[3] == 2'b00) && win2_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit3_reg <= hit_next;
            c1_reg   <= CW'(cp_reg[0]) - CW'(cp_reg[1]);
            c2_reg   <= CW'(cp_reg[2]) - CW'(cp_reg[3]);
            den3_reg <= OW'(dp0_reg) - OW'(dp1_reg);
            ex3_reg  <= ex2_reg;
            ez3_reg  <= ez2_reg;
            fx3_reg  <= fx2_reg;
            fz3_reg  <= fz2_reg;
        end
    end

    // stage 4: numerator products
    logic signed [MW-1:0] m_reg [0:3];
    logic signed [OW-1:0] den4_reg;
    logic                 hit4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= c2_reg * ex3_reg;
            m_reg[1] <= c1_reg * fx3_reg;
            m_reg[2] <= c2_reg * ez3_reg;
            m_reg[3] <= c1_reg * fz3_reg;
            den4_reg <= den3_reg;
            hit4_reg <= hit3_reg;
        end
    end

    // stage 5: numerators
    logic signed [NW-1:0] nx_reg, nz_reg;
    logic signed [OW-1:0] den5_reg;
    logic                 hit5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg   <= NW'(m_reg[0]) - NW'(m_reg[1]);
            nz_reg   <= NW'(m_reg[2]) - NW'(m_reg[3]);
            den5_reg <= den4_reg;
            hit5_reg <= hit4_reg;
        end
    end

    // stage 6 and divider: restoring division, one quotient bit per stage
    logic [RW-1:0] rx_reg [0:QB];
    logic [RW-1:0] rz_reg [0:QB];
    logic [QB-1:0] qx_reg [0:QB];
    logic [QB-1:0] qz_reg [0:QB];
    logic [OW-1:0] ud_reg [0:QB];
    logic          sx_reg [0:QB];
    logic          sz_reg [0:QB];
    logic          hd_reg [0:QB];
    logic          pd_reg [0:QB];
    logic          go6;
    logic          dz6;
    logic [NW-1:0] ax6, az6;
    logic [OW-1:0] ad6;

    always_comb
    begin
        dz6 = (den5_reg == '0);
        go6 = hit5_reg && !dz6;
        ax6 = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        az6 = nz_reg[NW-1] ? NW'(-nz_reg) : NW'(nz_reg);
        ad6 = den5_reg[OW-1] ? OW'(-den5_reg) : OW'(den5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // zero numerator when no point is produced, so the quotient comes out zero
            rx_reg[0] <= go6 ? RW'(ax6) : '0;
            rz_reg[0] <= go6 ? RW'(az6) : '0;
            ud_reg[0] <= dz6 ? OW'(1) : ad6;
            qx_reg[0] <= '0;
            qz_reg[0] <= '0;
            sx_reg[0] <= nx_reg[NW-1] ^ den5_reg[OW-1];
            sz_reg[0] <= nz_reg[NW-1] ^ den5_reg[OW-1];
            hd_reg[0] <= hit5_reg;
            pd_reg[0] <= hit5_reg && dz6;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int B = QB - 1 - k;
        logic [RW-1:0] sh;
        logic          gx, gz;

        assign sh = RW'({{QB{1'b0}}, ud_reg[k]} << B);
        assign gx = (rx_reg[k] >= sh);
        assign gz = (rz_reg[k] >= sh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1]    <= gx ? rx_reg[k] - sh : rx_reg[k];
                rz_reg[k+1]    <= gz ? rz_reg[k] - sh : rz_reg[k];
                qx_reg[k+1]    <= qx_reg[k] | (QB'(gx) << B);
                qz_reg[k+1]    <= qz_reg[k] | (QB'(gz) << B);
                ud_reg[k+1]    <= ud_reg[k];
                sx_reg[k+1]    <= sx_reg[k];
                sz_reg[k+1]    <= sz_reg[k];
                hd_reg[k+1]    <= hd_reg[k];
                pd_reg[k+1]    <= pd_reg[k];
            end
        end
    end

    // output register: apply sign and clamp to the coordinate range
    function automatic logic [CB-1:0] clamp(logic [QB-1:0] q, logic s);
        logic [CB-1:0] r;
        if (s)
        begin
            r = (q > LIM) ? CB'(LIM) : CB'(QB'(0) - q);
        end
        else
        begin
            r = (q >= LIM) ? CB'(LIM - QB'(1)) : CB'(q);
        end
        return r;
    endfunction

    logic          hit_reg, par_reg;
    logic [CB-1:0] cx_reg, cz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hd_reg[QB];
            par_reg <= pd_reg[QB];
            cx_reg  <= clamp(qx_reg[QB], sx_reg[QB]);
            cz_reg  <= clamp(qz_reg[QB], sz_reg[QB]);
        end
    end

    assign hit      = hit_reg;
    assign parallel = par_reg;
    assign cross_x  = cx_reg;
    assign cross_z  = cz_reg;

    `SIP_ASSERT_IMP(a_nohit_zero, clk, rst_n, out_valid && !hit, !parallel && cross_x == '0 && cross_z == '0)
    `SIP_ASSERT_IMP(a_par_zero, clk, rst_n, out_valid && parallel, hit && cross_x == '0 && cross_z == '0)
    `SIP_ASSERT_NXT(a_enter, clk, rst_n, in_valid && in_ready, vld_reg[0])
    `SIP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cross_x) && $stable(hit))
endmodule
